// File: src/krx_pkg.sv
// ----------------------------------------------------------------------------
// krx_pkg
// Shared codes, widths and control/status bundles of the record sorter.
// ----------------------------------------------------------------------------
package krx_pkg;

	// default store depth
	localparam int DEF_MAX_ENTRIES = 512;

	// payload widths
	localparam int KEY_W     = 32;
	localparam int TAG_W     = 9;
	localparam int REC_W     = KEY_W + TAG_W;
	localparam int POS_W     = 9;
	localparam int CNT_OUT_W = 10;

	// request codes
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_SORT   = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic       re;          // read the store
		logic       rd_pos;      // read address is the request position
		logic       we;          // write the store
		logic       wr_cur;      // write the held record (else the appended one)
		logic       ld_cur;      // load held record from read data
		logic       cnt_inc;     // count one more record
		logic       cnt_clr;     // empty the store
		logic       emit;        // present a result next cycle
		logic       emit_read;   // result carries read data
		logic [1:0] emit_status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;    // count at capacity
		logic pos_ok;  // read position below count
		logic multi;   // two or more records held
		logic swap;    // held record and read record out of order
	} sts_t;

endpackage

// File: src/krx_ctrl.sv
// ----------------------------------------------------------------------------
// krx_ctrl
// Request decoder and exchange sort sequencer of the record sorter.
// ----------------------------------------------------------------------------
module krx_ctrl #(
	parameter int MAX_ENTRIES = krx_pkg::DEF_MAX_ENTRIES,
	parameter int AW          = $clog2(MAX_ENTRIES),
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	output logic             busy,
	input  krx_pkg::sts_t    sts,
	input  logic [CW-1:0]    count,
	output krx_pkg::cmd_t    cmd,
	output logic [AW-1:0]    rd_addr,
	output logic [AW-1:0]    wr_addr
);
	import krx_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LDI   = 3'd1;
	localparam logic [2:0] S_FIRST = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_WRI   = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] i_q, i_d;
	logic [AW-1:0] j_q, j_d;
	logic          j_more;
	logic          i_more;

	// another compare left in this row, another row left in the pass
	assign j_more = (CW'(j_q) + CW'(1)) < count;
	assign i_more = (CW'(i_q) + CW'(2)) < count;
	assign busy   = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		wr_addr = '0;
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_APPEND: begin
							cmd.emit = 1'b1;
							if (sts.full) begin
								cmd.emit_status = ST_FULL;
							end else begin
								cmd.we      = 1'b1;
								cmd.cnt_inc = 1'b1;
								cmd.emit_status = ST_OK;
							end
						end
						REQ_SORT: begin
							if (sts.multi) begin
								i_d     = '0;
								state_d = S_LDI;
							end else begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_OK;
							end
						end
						REQ_READ: begin
							cmd.emit = 1'b1;
							if (sts.pos_ok) begin
								cmd.re          = 1'b1;
								cmd.rd_pos      = 1'b1;
								cmd.emit_read   = 1'b1;
								cmd.emit_status = ST_OK;
							end else begin
								cmd.emit_status = ST_RANGE;
							end
						end
						REQ_CLEAR: begin
							cmd.cnt_clr     = 1'b1;
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_OK;
						end
						default: begin
							cmd.emit = 1'b0;
						end
					endcase
				end
			end
			S_LDI: begin
				cmd.re  = 1'b1;
				rd_addr = i_q;
				state_d = S_FIRST;
			end
			S_FIRST: begin
				cmd.ld_cur = 1'b1;
				cmd.re     = 1'b1;
				rd_addr    = i_q + AW'(1);
				j_d        = i_q + AW'(1);
				state_d    = S_CMP;
			end
			S_CMP: begin
				// swap: old held record goes to j, record j becomes held
				if (sts.swap) begin
					cmd.we     = 1'b1;
					cmd.wr_cur = 1'b1;
					cmd.ld_cur = 1'b1;
					wr_addr    = j_q;
				end
				if (j_more) begin
					cmd.re  = 1'b1;
					rd_addr = j_q + AW'(1);
					j_d     = j_q + AW'(1);
				end else begin
					state_d = S_WRI;
				end
			end
			S_WRI: begin
				// settle position i; in the same cycle start the next row, or end the sort after the last
				cmd.we     = 1'b1;
				cmd.wr_cur = 1'b1;
				wr_addr    = i_q;
				if (i_more) begin
					cmd.re  = 1'b1;
					rd_addr = i_q + AW'(1);
					i_d     = i_q + AW'(1);
					state_d = S_FIRST;
				end else begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_OK;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// a swap write never lands on the address being read
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.we && cmd.re && !cmd.rd_pos && cmd.wr_cur) |-> (wr_addr != rd_addr))
		else $error("store read and write collide");

	// compare index stays inside the held records
	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (CW'(j_q) < count))
		else $error("compare index beyond count");

	// compare index always follows the held position
	a_i_below_j: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (i_q < j_q))
		else $error("compare index not above held position");

	// count holds still through a sort
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count))
		else $error("count changed during sort");

endmodule

// File: src/krx_dp.sv
// ----------------------------------------------------------------------------
// krx_dp
// Record store, held record, count, order register and result registers.
// ----------------------------------------------------------------------------
module krx_dp #(
	parameter int MAX_ENTRIES = krx_pkg::DEF_MAX_ENTRIES,
	parameter int AW          = $clog2(MAX_ENTRIES),
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  krx_pkg::cmd_t                       cmd,
	input  logic [AW-1:0]                       rd_addr,
	input  logic [AW-1:0]                       wr_addr,
	output krx_pkg::sts_t                       sts,
	output logic [CW-1:0]                       count,
	input  logic signed [krx_pkg::KEY_W-1:0]    rec_key,
	input  logic [krx_pkg::TAG_W-1:0]           rec_tag,
	input  logic [krx_pkg::POS_W-1:0]           position,
	input  logic                                cfg_valid,
	input  logic                                cfg_data,
	output logic                                done,
	output logic signed [krx_pkg::KEY_W-1:0]    out_key,
	output logic [krx_pkg::TAG_W-1:0]           out_tag,
	output logic [krx_pkg::CNT_OUT_W-1:0]       entry_count,
	output logic [1:0]                          status
);
	import krx_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [REC_W-1:0] mem_q [MAX_ENTRIES];
	logic [REC_W-1:0] rd_data_q;
	logic [REC_W-1:0] cur_q;
	logic [REC_W-1:0] wr_data;
	logic [AW-1:0]    mem_wr_addr;
	logic [AW-1:0]    mem_rd_addr;
	logic [CW-1:0]    count_q;
	logic             ascending_q;
	logic             done_q;
	logic             read_q;
	logic [1:0]       status_q;
	logic signed [KEY_W-1:0] cur_key;
	logic signed [KEY_W-1:0] rd_key;

	// store port address and data selection
	assign wr_data     = cmd.wr_cur ? cur_q : {rec_key, rec_tag};
	assign mem_wr_addr = cmd.wr_cur ? wr_addr : AW'(count_q);
	assign mem_rd_addr = cmd.rd_pos ? AW'(position) : rd_addr;

	// record store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[mem_wr_addr] <= wr_data;
		end
		if (cmd.re) begin
			rd_data_q <= mem_q[mem_rd_addr];
		end
	end

	// held record of the current sort row
	always_ff @(posedge clk) begin
		if (cmd.ld_cur) begin
			cur_q <= rd_data_q;
		end
	end

	// strict signed compare in the selected order
	assign cur_key = cur_q[REC_W-1:TAG_W];
	assign rd_key  = rd_data_q[REC_W-1:TAG_W];
	assign sts.swap   = ascending_q ? (cur_key > rd_key) : (cur_key < rd_key);
	assign sts.full   = (count_q == CW'(MAX_ENTRIES));
	assign sts.multi  = (count_q >= CW'(2));
	assign sts.pos_ok = (CMPW'(position) < CMPW'(count_q))
		&& (CMPW'(position) < CMPW'(MAX_ENTRIES));
	assign count = count_q;

	// count, order register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ascending_q <= 1'b1;
			done_q      <= 1'b0;
			read_q      <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cfg_valid) begin
				ascending_q <= cfg_data;
			end
			done_q <= cmd.emit;
			if (cmd.emit) begin
				read_q   <= cmd.emit_read;
				status_q <= cmd.emit_status;
			end
		end
	end

	// result ports, shown for the strobe cycle
	assign done        = done_q;
	assign out_key     = read_q ? rd_key : '0;
	assign out_tag     = read_q ? rd_data_q[TAG_W-1:0] : '0;
	assign entry_count = CNT_OUT_W'(count_q);
	assign status      = status_q;

endmodule

// File: src/keyed_record_exchange_sorter.sv
// ----------------------------------------------------------------------------
// keyed_record_exchange_sorter
// Record store with append, read, clear and in-place exchange sort requests.
// ----------------------------------------------------------------------------
// Usage:
//  - a request transfers on a clock edge with start high and busy low;
//    req_type picks append, sort, read or clear
//  - every request gives one result: done is high for one cycle with
//    out_key, out_tag, entry_count and status valid in that cycle only;
//    the receiver cannot stall, so it must take the result when shown
//  - append, read, clear and a sort of fewer than two records: done comes
//    in the cycle after the transfer and busy stays low, so one request per
//    cycle is taken
//  - sort of two or more records: busy goes high after the transfer and
//    falls in the cycle the result is shown; each held record is compared
//    with every later one, one compare per cycle, swapping when out of
//    order; the store does at most one read and one write per cycle
//  - cfg_valid writes the order register (cfg_ready is always high); the user
//    must do so only while no request is outstanding; the block does not check
//  - reset empties the store and selects ascending order; store contents
//    are not cleared and are never read beyond the count
// ----------------------------------------------------------------------------
module keyed_record_exchange_sorter #(
	parameter int MAX_ENTRIES = krx_pkg::DEF_MAX_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic signed [krx_pkg::KEY_W-1:0]    rec_key,
	input  logic [krx_pkg::TAG_W-1:0]           rec_tag,
	input  logic [krx_pkg::POS_W-1:0]           position,
	output logic                                done,
	output logic signed [krx_pkg::KEY_W-1:0]    out_key,
	output logic [krx_pkg::TAG_W-1:0]           out_tag,
	output logic [krx_pkg::CNT_OUT_W-1:0]       entry_count,
	output logic [1:0]                          status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);
	import krx_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [CW-1:0] count;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign cfg_ready = 1'b1;

	// controller
	krx_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.busy     (busy),
		.sts      (sts),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	// datapath
	krx_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.sts         (sts),
		.count       (count),
		.rec_key     (rec_key),
		.rec_tag     (rec_tag),
		.position    (position),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.done        (done),
		.out_key     (out_key),
		.out_tag     (out_tag),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule
